// File: rtl/sighting_record_table_assert.svh
// Assertion macros used by the sighting record table controller.
`ifndef SIGHTING_RECORD_TABLE_ASSERT_SVH
`define SIGHTING_RECORD_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sighting record table: assertion failed");

// Next-cycle implication, checked outside reset.
`define SRT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sighting record table: assertion failed");

`endif

// File: rtl/srt_pkg.sv
// Types and constants shared by the sighting record table modules.
`timescale 1ns / 1ps
package srt_pkg;

    typedef enum logic [1:0] {
        KIND_NOTE  = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_EN      = 1'b1;

    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 96;
    localparam int CFG_DATA_W = 32;

    localparam logic signed [7:0] RSSI_NONE         = -8'sd128;
    localparam logic [15:0]       COUNT_MAX         = 16'hFFFF;
    localparam logic [31:0]       PERSIST_DELAY_RST = 32'd10000;

    typedef struct packed {
        logic [31:0]       first_epoch;
        logic [31:0]       last_epoch;
        logic signed [7:0] best_signal;
        logic [15:0]       night_total;
        logic              best_improved;
    } rec_t;

    typedef struct packed {
        logic [15:0]       count;
        logic signed [7:0] strongest;
    } pend_t;

    localparam rec_t  REC_RESET  = '{32'd0, 32'd0, RSSI_NONE, 16'd0, 1'b0};
    localparam pend_t PEND_RESET = '{16'd0, RSSI_NONE};

    typedef struct packed {
        logic capture;
        logic lookup;
        logic walk;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic walk_last;
    } status_t;

    typedef struct packed {
        logic              type_valid;
        logic [31:0]       first_seen;
        logic [31:0]       last_seen;
        logic signed [7:0] strongest_rssi;
        logic [15:0]       night_sightings;
        logic              new_best;
        logic              persist_request;
    } result_t;

endpackage

// File: rtl/sighting_record_table.sv
// Top level of the sighting record table: ports, configuration registers, result packing.
`timescale 1ns / 1ps
// Per-class sighting statistics table with NUM_TYPES entries. One item is taken
// at a time: s_tready is high only while the block is free. A note, read or
// clear-all item passes through capture, memory lookup and result. A tick item
// passes through capture and lookup, then walks the pending and record
// memories at one entry per cycle over their single read and single write
// port, then gives its result. The finished result sits in an output register,
// so it may wait on m_tready while the next item is accepted and worked; that
// item only stalls in its finish state if the earlier result is still
// unclaimed. No clearing pass runs after reset: every entry has a valid bit,
// and clear-all and tick drop whole tables of them at once. Configuration
// writes are always taken (cfg_ready tied high) and must only arrive while the
// block is idle.
module sighting_record_table #(
    parameter int NUM_TYPES = 17
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // type_code[7:0], rssi[15:8], now_ms[47:16], clock_trusted[48],
    // epoch_now[80:49], is_night[81], take_flag[82], zero fill [87:83]
    input  logic [srt_pkg::S_TDATA_W-1:0]      s_tdata,
    // kind[1:0]
    input  logic [srt_pkg::S_TUSER_W-1:0]      s_tuser,
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // type_valid[0], first_seen[32:1], last_seen[64:33], strongest_rssi[72:65],
    // night_sightings[88:73], new_best[89], persist_request[90], zero fill [95:91]
    output logic [srt_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [srt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [31:0]      persist_delay_reg;
    logic             store_en_reg;
    srt_pkg::cmd_t    cmd;
    srt_pkg::status_t status;
    srt_pkg::result_t result;

    // Configuration registers; a write lands directly in its register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            persist_delay_reg <= srt_pkg::PERSIST_DELAY_RST;
            store_en_reg      <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                srt_pkg::CFG_PERSIST_DELAY: persist_delay_reg <= cfg_data;
                srt_pkg::CFG_STORE_EN:      store_en_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencing of capture, lookup, walk and hand-off.
    srt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // Tables, per-entry update logic and persist timing.
    srt_datapath #(
        .NUM_TYPES (NUM_TYPES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .persist_delay (persist_delay_reg),
        .store_en      (store_en_reg),
        .result        (result)
    );

    // Result packing, first field in the lowest bits.
    assign m_tdata = {5'd0,
                      result.persist_request,
                      result.new_best,
                      result.night_sightings,
                      result.strongest_rssi,
                      result.last_seen,
                      result.first_seen,
                      result.type_valid};

endmodule

// File: rtl/srt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                    wr_data,
    input  logic                                rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                    rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/srt_ctrl.sv
// Controller state machine: item handshake, record walk and result hand-off.
`timescale 1ns / 1ps
`include "sighting_record_table_assert.svh"
module srt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output srt_pkg::cmd_t    cmd,
    input  srt_pkg::status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = status.is_tick ? ST_WALK : ST_FINISH;
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (status.walk_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.finish    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    `SRT_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.finish, !m_tvalid_reg || m_tready)
    `SRT_ASSERT_NXT(a_walk_ends, aclk, aresetn, state_reg == ST_WALK && status.walk_last,
                    state_reg == ST_FINISH)
    `SRT_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

// File: rtl/srt_datapath.sv
// Datapath: item registers, pending and record memories, persist timing.
`timescale 1ns / 1ps
module srt_datapath #(
    parameter int NUM_TYPES = 17
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  srt_pkg::cmd_t                     cmd,
    output srt_pkg::status_t                  status,
    input  logic [srt_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [srt_pkg::S_TUSER_W-1:0]     s_tuser,
    input  logic [31:0]                       persist_delay,
    input  logic                              store_en,
    output srt_pkg::result_t                  result
);

    localparam int IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_TYPES - 1);
    localparam logic [7:0]       CODE_LIMIT = 8'(NUM_TYPES);

    // captured item
    srt_pkg::kind_t     kind_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic               slot_ok_reg;
    logic signed [7:0]  rssi_reg;
    logic [31:0]        now_reg;
    logic               trusted_reg;
    logic [31:0]        epoch_reg;
    logic               night_reg;
    logic               take_reg;

    logic [7:0]         code;

    // walk and lookup
    logic [IDX_W-1:0]   wk_reg;
    logic [IDX_W-1:0]   rdq_addr_reg;
    logic               any_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;

    // per-entry valid bits; an invalid entry reads as its reset value
    logic [NUM_TYPES-1:0] pend_vld_reg;
    logic [NUM_TYPES-1:0] rec_vld_reg;
    logic                 unsaved_reg;
    logic [31:0]          change_time_reg;

    logic [$bits(srt_pkg::pend_t)-1:0] pend_q;
    logic [$bits(srt_pkg::rec_t)-1:0]  rec_q;
    srt_pkg::pend_t pend_eff, pend_upd;
    srt_pkg::rec_t  rec_eff, rec_upd, rec_take, rec_wdata;
    logic           pend_hit;
    logic [16:0]    night_sum;

    logic             rec_we, pend_we;
    logic [IDX_W-1:0] rec_waddr;

    logic             unsaved_eff, persist_req;
    logic [31:0]      ct_eff, quiet;

    srt_pkg::result_t result_reg, result_next;

    assign code = s_tdata[7:0];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg    <= srt_pkg::kind_t'(s_tuser);
            slot_ok_reg <= (code != 8'd0) && (code <= CODE_LIMIT);
            slot_reg    <= IDX_W'(code - 8'd1);
            rssi_reg    <= s_tdata[15:8];
            now_reg     <= s_tdata[47:16];
            trusted_reg <= s_tdata[48];
            epoch_reg   <= s_tdata[80:49];
            night_reg   <= s_tdata[81];
            take_reg    <= s_tdata[82];
        end
    end

    always_comb begin
        if (cmd.walk) begin
            rd_addr = wk_reg + IDX_W'(1);
        end else if (kind_reg == srt_pkg::KIND_TICK) begin
            rd_addr = '0;
        end else begin
            rd_addr = slot_reg;
        end
        rd_en = (cmd.lookup && (kind_reg == srt_pkg::KIND_TICK || slot_ok_reg))
             || (cmd.walk && !status.walk_last);
    end

    assign status.is_tick   = (kind_reg == srt_pkg::KIND_TICK);
    assign status.walk_last = (wk_reg == LAST_IDX);

    srt_ram #(
        .WIDTH ($bits(srt_pkg::pend_t)),
        .DEPTH (NUM_TYPES)
    ) u_pend_ram (
        .aclk    (aclk),
        .wr_en   (pend_we),
        .wr_addr (slot_reg),
        .wr_data (pend_upd),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (pend_q)
    );

    srt_ram #(
        .WIDTH ($bits(srt_pkg::rec_t)),
        .DEPTH (NUM_TYPES)
    ) u_rec_ram (
        .aclk    (aclk),
        .wr_en   (rec_we),
        .wr_addr (rec_waddr),
        .wr_data (rec_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rec_q)
    );

    assign pend_eff = pend_vld_reg[rdq_addr_reg] ? srt_pkg::pend_t'(pend_q)
                                                 : srt_pkg::PEND_RESET;
    assign rec_eff  = rec_vld_reg[rdq_addr_reg] ? srt_pkg::rec_t'(rec_q)
                                                : srt_pkg::REC_RESET;
    assign pend_hit = (pend_eff.count != 16'd0);

    // fold pending sightings into the record of the walked entry
    always_comb begin
        rec_upd   = rec_eff;
        night_sum = {1'b0, rec_eff.night_total} + {1'b0, pend_eff.count};
        if (trusted_reg) begin
            if (rec_eff.first_epoch == 32'd0) begin
                rec_upd.first_epoch = epoch_reg;
            end
            rec_upd.last_epoch = epoch_reg;
            if (night_reg) begin
                rec_upd.night_total = night_sum[16] ? srt_pkg::COUNT_MAX : night_sum[15:0];
            end
        end
        if (pend_eff.strongest > rec_eff.best_signal) begin
            if (rec_eff.best_signal > srt_pkg::RSSI_NONE) begin
                rec_upd.best_improved = 1'b1;
            end
            rec_upd.best_signal = pend_eff.strongest;
        end
    end

    always_comb begin
        rec_take               = rec_eff;
        rec_take.best_improved = 1'b0;
        pend_upd.count     = (pend_eff.count == srt_pkg::COUNT_MAX) ? pend_eff.count
                                                                    : pend_eff.count + 16'd1;
        pend_upd.strongest = (rssi_reg > pend_eff.strongest) ? rssi_reg : pend_eff.strongest;
    end

    assign rec_we    = (cmd.walk && pend_hit)
                    || (cmd.finish && kind_reg == srt_pkg::KIND_READ && slot_ok_reg && take_reg);
    assign rec_waddr = cmd.walk ? wk_reg : slot_reg;
    assign rec_wdata = cmd.walk ? rec_upd : rec_take;
    assign pend_we   = cmd.finish && kind_reg == srt_pkg::KIND_NOTE && slot_ok_reg;

    // persist check after the walk: any touched entry restamps the change time
    assign unsaved_eff = unsaved_reg || any_reg;
    assign ct_eff      = any_reg ? now_reg : change_time_reg;
    assign quiet       = now_reg - ct_eff;
    assign persist_req = store_en && unsaved_eff && (quiet >= persist_delay);

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            wk_reg <= '0;
        end else if (cmd.walk) begin
            wk_reg <= wk_reg + IDX_W'(1);
        end
        if (rd_en) begin
            rdq_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg    <= '0;
            rec_vld_reg     <= '0;
            unsaved_reg     <= 1'b0;
            change_time_reg <= 32'd0;
            any_reg         <= 1'b0;
        end else begin
            if (rec_we) begin
                rec_vld_reg[rec_waddr] <= 1'b1;
            end
            if (pend_we) begin
                pend_vld_reg[slot_reg] <= 1'b1;
            end
            if (cmd.lookup) begin
                any_reg <= 1'b0;
            end else if (cmd.walk && pend_hit) begin
                any_reg <= 1'b1;
            end
            if (cmd.finish) begin
                case (kind_reg)
                    srt_pkg::KIND_TICK: begin
                        pend_vld_reg    <= '0;
                        unsaved_reg     <= unsaved_eff && !persist_req;
                        change_time_reg <= ct_eff;
                    end
                    srt_pkg::KIND_CLEAR: begin
                        rec_vld_reg <= '0;
                        unsaved_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        result_next = '0;
        case (kind_reg)
            srt_pkg::KIND_NOTE: begin
                result_next.type_valid = slot_ok_reg;
            end
            srt_pkg::KIND_TICK: begin
                result_next.persist_request = persist_req;
            end
            srt_pkg::KIND_READ: begin
                result_next.type_valid = slot_ok_reg;
                if (slot_ok_reg) begin
                    result_next.first_seen      = rec_eff.first_epoch;
                    result_next.last_seen       = rec_eff.last_epoch;
                    result_next.strongest_rssi  = rec_eff.best_signal;
                    result_next.night_sightings = rec_eff.night_total;
                    result_next.new_best        = rec_eff.best_improved;
                end else begin
                    result_next.strongest_rssi = srt_pkg::RSSI_NONE;
                end
            end
            default: begin
                result_next.persist_request = store_en;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
